// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file spq_checker.
// Depends on nothing; take it in by include before the module that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

// ===== src/spq_pkg.sv =====
// Package of the sorted priority queue: entry type, codes, cell request struct.
// Depends on nothing; used by spq_cell, sorted_priority_queue and spq_checker.
`default_nettype none

package spq_pkg;

  localparam int DEFAULT_DEPTH = 16;
  localparam int PRIO_W        = 16;
  localparam int TAG_W         = 32;
  localparam int COUNT_OUT_W   = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_EMPTY_REMOVE = 2'd1,
    ST_FULL_INSERT  = 2'd2
  } status_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic   insert;
    logic   remove;
    entry_t item;
  } cell_req_t;

endpackage

`default_nettype wire

// ===== src/spq_cell.sv =====
// One slot of the sorted chain: holds an entry, hands it to a neighbor on shift.
// Depends on spq_pkg.
`default_nettype none

module spq_cell #(
  parameter int COUNT_W = 5,
  parameter int IDX     = 0
) (
  input  wire                    clk,
  input  spq_pkg::cell_req_t     req,
  input  wire [COUNT_W-1:0]      count,
  input  wire                    prev_keep,
  input  spq_pkg::entry_t        prev_entry,
  input  spq_pkg::entry_t        next_entry,
  output logic                   keep,
  output spq_pkg::entry_t        entry,
  output spq_pkg::entry_t        entry_next
);
  import spq_pkg::*;

  logic occupied;

  assign occupied = count > COUNT_W'(IDX);
  assign keep     = occupied && ($signed(entry.prio) > $signed(req.item.prio));

  always_comb begin
    entry_next = entry;
    if (req.insert) begin
      if (keep) begin
        entry_next = entry;
      end else if (prev_keep) begin
        entry_next = req.item;
      end else begin
        entry_next = prev_entry;
      end
    end else if (req.remove) begin
      entry_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

// ===== src/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: chain of spq_cell slots, count, result register.
// Depends on spq_pkg and spq_cell.
//
//   channel   dir  tdata (low bit up)                           tuser
//   s_axis    in   entry_priority[15:0] entry_payload[47:16]    operation
//   m_axis    out  top_priority[15:0] top_payload[47:16]        -
//                  queue_empty[48] entry_count[53:49] status[55:54]
//
// One request per cycle while s_axis_tready is high: each insert or remove settles in the cell chain,
// every cell comparing against the broadcast entry and shifting by one toward a neighbor.
// The result of a request appears on m_axis the cycle after acceptance.
// s_axis_tready is high while the result register is empty or being drained.
// rst clears the entry count and the result valid; slot contents stay undefined.
`default_nettype none

module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_DEPTH
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [47:0] s_axis_tdata,   // entry_priority, entry_payload
  input  wire  [0:0]  s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [55:0] m_axis_tdata    // top_priority, top_payload, queue_empty,
                                      // entry_count, status
);
  import spq_pkg::*;

  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic               fire;
  logic               full;
  logic               empty;
  logic               is_insert;
  cell_req_t          req;
  status_t            status_next;
  entry_t             cell_q    [QUEUE_DEPTH];
  entry_t             cell_d    [QUEUE_DEPTH];
  logic               cell_keep [QUEUE_DEPTH];
  logic               res_empty;
  entry_t             res_head;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign fire          = s_axis_tvalid && s_axis_tready;
  assign full          = count == COUNT_W'(QUEUE_DEPTH);
  assign empty         = count == '0;
  assign is_insert     = s_axis_tuser[0] == OP_INSERT;

  assign req.insert    = fire && is_insert && !full;
  assign req.remove    = fire && !is_insert && !empty;
  assign req.item.prio = s_axis_tdata[15:0];
  assign req.item.tag  = s_axis_tdata[47:16];

  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    if (is_insert) begin
      if (full) begin
        status_next = ST_FULL_INSERT;
      end else begin
        count_next = count + COUNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_next = ST_EMPTY_REMOVE;
      end else begin
        count_next = count - COUNT_W'(1);
      end
    end
  end

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic   prev_keep;
      entry_t prev_entry;
      entry_t next_entry;

      if (i == 0) begin : g_head
        assign prev_keep  = 1'b1;
        assign prev_entry = '0;
      end else begin : g_body
        assign prev_keep  = cell_keep[i-1];
        assign prev_entry = cell_q[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
        assign next_entry = '0;
      end else begin : g_link
        assign next_entry = cell_q[i+1];
      end

      spq_cell #(
        .COUNT_W (COUNT_W),
        .IDX     (i)
      ) u_cell (
        .clk        (clk),
        .req        (req),
        .count      (count),
        .prev_keep  (prev_keep),
        .prev_entry (prev_entry),
        .next_entry (next_entry),
        .keep       (cell_keep[i]),
        .entry      (cell_q[i]),
        .entry_next (cell_d[i])
      );
    end
  endgenerate

  assign res_empty = count_next == '0;
  assign res_head  = res_empty ? entry_t'('0) : cell_d[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        count <= count_next;
      end
      if (fire) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_axis_tdata <= {status_next, COUNT_OUT_W'(count_next), res_empty,
                       res_head.tag, res_head.prio};
    end
  end

endmodule

`default_nettype wire

// ===== src/spq_checker.sv =====
// Port-level checks of the sorted priority queue, bound to the top level.
// Depends on spq_pkg, assert_macros.svh and sorted_priority_queue.
`default_nettype none
`include "assert_macros.svh"

module spq_checker #(
  parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_DEPTH
) (
  input wire        clk,
  input wire        rst,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [55:0] m_axis_tdata
);
  import spq_pkg::*;

  localparam logic [COUNT_OUT_W-1:0] DEPTH_MASKED = COUNT_OUT_W'(QUEUE_DEPTH);

  logic       res_empty;
  logic [4:0] res_count;
  logic [1:0] res_status;
  logic       in_fire;

  assign res_empty  = m_axis_tdata[48];
  assign res_count  = m_axis_tdata[53:49];
  assign res_status = m_axis_tdata[55:54];
  assign in_fire    = s_axis_tvalid && s_axis_tready;

  `ASSERT_IMPLY(a_empty_head_zero, clk, rst, m_axis_tvalid && res_empty,
                m_axis_tdata[47:0] == 48'd0 && res_count == 5'd0)
  `ASSERT_IMPLY(a_full_count, clk, rst, m_axis_tvalid && res_status == ST_FULL_INSERT,
                res_count == DEPTH_MASKED && !res_empty)
  `ASSERT_IMPLY(a_empty_remove, clk, rst, m_axis_tvalid && res_status == ST_EMPTY_REMOVE,
                res_empty)
  `ASSERT_NEXT(a_result_follows, clk, rst, in_fire, m_axis_tvalid)
  `ASSERT_NEXT(a_hold_stalled, clk, rst, m_axis_tvalid && !m_axis_tready,
               m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind sorted_priority_queue spq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_spq_checker (.*);

`default_nettype wire

// ===== tb/spq_head_checker.sv =====
`timescale 1ns / 1ps
// Checker for sorted_priority_queue: tracks its own sorted copy of the queue from every
// accepted request and checks each accepted result against it. Depends on spq_pkg.
module spq_head_checker
  import spq_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_axis_tvalid,
  input  wire        s_axis_tready,
  input  wire [47:0] s_axis_tdata,   // entry_priority, entry_payload
  input  wire [0:0]  s_axis_tuser,   // operation
  input  wire        m_axis_tvalid,
  input  wire        m_axis_tready,
  input  wire [55:0] m_axis_tdata,   // top_priority, top_payload, queue_empty,
                                     // entry_count, status
  output int         fail_count,
  output int         pending
);

  typedef struct {
    logic [PRIO_W-1:0]      prio;
    logic [TAG_W-1:0]       tag;
    logic                   empty;
    logic [COUNT_OUT_W-1:0] count;
    logic [1:0]             status;
  } head_report_t;

  head_report_t expected_heads[$];
  entry_t       sorted_entries[DEPTH];
  int           held;

  function automatic head_report_t apply_request(input logic op,
                                                 input logic [PRIO_W-1:0] prio,
                                                 input logic [TAG_W-1:0] tag);
    head_report_t r;
    status_t      st;
    int           pos;
    int           i;
    st = ST_OK;
    if (op == OP_INSERT) begin
      if (held >= DEPTH) begin
        st = ST_FULL_INSERT;
      end else begin
        pos = 0;
        while (pos < held && $signed(sorted_entries[pos].prio) > $signed(prio)) pos++;
        for (i = held; i > pos; i--) sorted_entries[i] = sorted_entries[i-1];
        sorted_entries[pos].prio = prio;
        sorted_entries[pos].tag  = tag;
        held++;
      end
    end else if (held == 0) begin
      st = ST_EMPTY_REMOVE;
    end else begin
      for (i = 0; i < held - 1; i++) sorted_entries[i] = sorted_entries[i+1];
      held--;
    end
    r.empty  = (held == 0);
    r.prio   = r.empty ? '0 : sorted_entries[0].prio;
    r.tag    = r.empty ? '0 : sorted_entries[0].tag;
    r.count  = COUNT_OUT_W'(held);
    r.status = st;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    head_report_t want;
    head_report_t got;
    if (rst) begin
      held = 0;
      fail_count = 0;
      expected_heads.delete();
      pending <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.prio   = m_axis_tdata[15:0];
        got.tag    = m_axis_tdata[47:16];
        got.empty  = m_axis_tdata[48];
        got.count  = m_axis_tdata[53:49];
        got.status = m_axis_tdata[55:54];
        if (expected_heads.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: prio %0d tag %h empty %0d count %0d status %0d",
                     $signed(got.prio), got.tag, got.empty, got.count, got.status);
        end else begin
          want = expected_heads.pop_front();
          if (got.prio !== want.prio || got.tag !== want.tag || got.empty !== want.empty ||
              got.count !== want.count || got.status !== want.status) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("head mismatch: expected prio %0d tag %h empty %0d count %0d status %0d",
                       $signed(want.prio), want.tag, want.empty, want.count, want.status);
              $display("               actual   prio %0d tag %h empty %0d count %0d status %0d",
                       $signed(got.prio), got.tag, got.empty, got.count, got.status);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_heads.push_back(apply_request(s_axis_tuser[0], s_axis_tdata[15:0],
                                               s_axis_tdata[47:16]));
      pending <= expected_heads.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the sorted_priority_queue testbench: clock, reset, insert/remove requests,
// random back-pressure and the verdict. Depends on spq_pkg and spq_head_checker.
module tb_top;
  import spq_pkg::*;

  localparam int DEPTH       = DEFAULT_DEPTH;
  localparam int ITEMS       = 1650;
  localparam int STALL_LIMIT = 2000;

  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic [47:0] s_axis_tdata  = '0;   // entry_priority, entry_payload
  logic [0:0]  s_axis_tuser  = '0;   // operation
  logic        m_axis_tready = 1'b0;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [55:0] m_axis_tdata;         // top_priority, top_payload, queue_empty,
                                     // entry_count, status
  int          fail_count;
  int          pending;
  int          stall_cycles = 0;
  bit          steady = 1'b0;

  sorted_priority_queue #(.QUEUE_DEPTH(DEPTH)) DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  spq_head_checker #(.DEPTH(DEPTH)) u_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // result side: random hold-off, except in steady phases, before taking each result
  initial begin : drain
    int hold;
    do @(posedge clk); while (rst);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  task automatic offer(input logic op, input logic [15:0] prio, input logic [31:0] tag);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {tag, prio};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // hold requests until every result is back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [15:0] pick_priority(input int kind);
    logic [15:0] p;
    case (kind)
      0: p = 16'($urandom);
      1: p = 16'($urandom_range(0, 4)) - 16'd2;
      default: begin
        case ($urandom_range(0, 3))
          0: p = 16'h8000;
          1: p = 16'h7fff;
          2: p = 16'h0000;
          default: p = 16'hffff;
        endcase
      end
    endcase
    return p;
  endfunction

  initial begin : stimulus
    int   sent;
    int   phase_len;
    int   insert_pct;
    int   kind;
    logic op;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // remove on empty with junk fields, extremes, ties, fill, full drops, a few removes
    offer(OP_REMOVE, 16'h1234, 32'hdeadbeef);
    offer(OP_INSERT, 16'h7fff, 32'hffffffff);
    offer(OP_INSERT, 16'h8000, 32'h00000000);
    offer(OP_INSERT, 16'h0000, 32'h00000001);
    offer(OP_INSERT, 16'hffff, 32'h00000002);
    offer(OP_INSERT, 16'd5, 32'h0000000a);
    offer(OP_INSERT, 16'd5, 32'h0000000b);
    offer(OP_INSERT, 16'd5, 32'h0000000c);
    repeat (DEPTH - 7) offer(OP_INSERT, 16'($urandom), $urandom);
    offer(OP_INSERT, 16'h7fff, 32'h55555555);
    offer(OP_INSERT, 16'h8000, 32'haaaaaaaa);
    repeat (3) offer(OP_REMOVE, 16'($urandom), $urandom);
    settle();

    sent = 0;
    while (sent < ITEMS) begin
      phase_len = $urandom_range(60, 180);
      if (phase_len > ITEMS - sent) phase_len = ITEMS - sent;
      case ($urandom_range(0, 2))
        0: insert_pct = 50;
        1: insert_pct = 75;
        default: insert_pct = 25;
      endcase
      kind   = $urandom_range(0, 2);
      steady = ($urandom_range(0, 3) == 0);
      repeat (phase_len) begin
        op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
        offer(op, pick_priority(kind), $urandom);
        sent++;
      end
      if ($urandom_range(0, 2) == 0) settle();
    end
    steady = 1'b0;

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sorted_priority_queue.f =====
+incdir+src
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue.sv
src/spq_checker.sv
tb/spq_head_checker.sv
tb/tb_top.sv
